[hw/rtl/afs_pkg.sv]
// Shared types and constants of the animation frame scheduler.
// No dependencies; imported by afs_step_unit, animation_frame_scheduler_core and the bench.
package afs_pkg;

   // field widths
   localparam int FRAME_W = 8;    // frame number as reported
   localparam int COUNT_W = 9;    // frame count register
   localparam int DELAY_W = 16;   // delay in centiseconds
   localparam int TIME_W  = 16;   // elapsed milliseconds
   localparam int PASS_W  = 16;   // completed passes
   localparam int DUR_W   = 20;   // delay scaled to milliseconds

   localparam int DEFAULT_MAX_FRAMES = 256;

   localparam logic [PASS_W-1:0] PASS_MAX = {PASS_W{1'b1}};

   // request kinds carried on tuser
   localparam logic CMD_WRITE_DELAY = 1'b0;
   localparam logic CMD_ADVANCE     = 1'b1;

   // configuration register indexes
   localparam logic CSR_LOOP_LIMIT  = 1'b0;
   localparam logic CSR_FRAME_COUNT = 1'b1;

   // outcome of one frame step of the walk
   typedef struct packed {
      logic              fits;       // remaining time covers a nonzero delay
      logic [TIME_W-1:0] remaining;  // time left after that frame
   } step_result_type;

endpackage

[hw/rtl/animation_frame_scheduler_core.sv]
// Animation frame scheduler top level: stream ports, delay table, walk sequencer.
// Depends on afs_pkg and afs_step_unit.
//
// A request with tuser 0 stores one frame delay (centiseconds) in the delay
// table; a request with tuser 1 advances the animation by an elapsed time in
// milliseconds, walking frame by frame from the current frame. Every request
// gives exactly one response carrying the changed flag, the current frame, the
// completed pass count and the finished flag. A delay write goes from the idle
// state straight to the done state, which loads the registered response, and
// so does an advance that has nothing to do. Any other advance passes through
// the walk state, which looks at one frame per cycle through the single table
// read port and the one shared scale, compare and subtract unit. A new
// request is taken only after the previous one has finished its walk; a
// response still waiting on rsp_tready does not hold back the next request.
// Delay entries are undefined until written, and an advance must not reach an
// unwritten entry.
module animation_frame_scheduler_core
   import afs_pkg::*;
#(
   parameter int MAX_FRAMES = DEFAULT_MAX_FRAMES
)
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [39:0]         req_tdata,   // frame_slot[7:0], frame_delay[23:8],
                                            // elapsed_time[39:24]
   input  logic                req_tuser,   // cmd[0]
   // response channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // changed[0], frame_index[8:1], loops_done[24:9],
                                            // done_res[25], zero[31:26]
   // configuration write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [15:0]         csr_data
);

   localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int IDX_W  = (ADDR_W > FRAME_W) ? ADDR_W : FRAME_W;
   localparam int CAP_I  = (MAX_FRAMES > 511) ? 511 : MAX_FRAMES;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_I);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // request fields
   logic [FRAME_W-1:0] req_slot;
   logic [DELAY_W-1:0] req_delay;
   logic [TIME_W-1:0]  req_elapsed;
   logic               req_fire;

   assign req_slot    = req_tdata[7:0];
   assign req_delay   = req_tdata[23:8];
   assign req_elapsed = req_tdata[39:24];

   // registers
   state_type          state_ff, state_in;
   logic [FRAME_W-1:0] walk_ff, walk_in;
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [FRAME_W-1:0] cur_ff, cur_in;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic               stopped_ff, stopped_in;
   logic [15:0]        loop_limit_ff, loop_limit_in;
   logic [COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   // delay table
   logic [DELAY_W-1:0] delay_mem [MAX_FRAMES];
   logic [DELAY_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  wr_addr;
   logic               rd_en;
   logic [FRAME_W-1:0] rd_frame;
   logic [ADDR_W-1:0]  rd_addr;
   logic [IDX_W-1:0]   wr_idx;
   logic [IDX_W-1:0]   rd_idx;
   logic               slot_ok;

   // walk helpers
   logic [COUNT_W-1:0] active_count;
   logic [COUNT_W-1:0] next_frame;
   logic [PASS_W-1:0]  pass_next;
   logic               limit_hit;
   step_result_type    step;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // frame count limited to the table size
   assign active_count = (frame_count_ff > COUNT_CAP) ? COUNT_CAP : frame_count_ff;

   // table addressing
   assign wr_idx  = IDX_W'(req_slot);
   assign wr_addr = wr_idx[ADDR_W-1:0];
   assign rd_idx  = IDX_W'(rd_frame);
   assign rd_addr = rd_idx[ADDR_W-1:0];
   assign slot_ok = (32'(req_slot) < 32'(MAX_FRAMES));
   assign mem_we  = req_fire && (req_tuser == CMD_WRITE_DELAY) && slot_ok;

   // shared scale, compare and subtract unit
   afs_step_unit u_step (
      .remaining   (rem_ff),
      .frame_delay (rd_data_ff),
      .result      (step)
   );

   // pass accounting for a wrap past the last frame
   assign next_frame = COUNT_W'(walk_ff) + COUNT_W'(1);
   assign pass_next  = (pass_ff == PASS_MAX) ? pass_ff : pass_ff + PASS_W'(1);
   assign limit_hit  = (loop_limit_ff != '0) && (pass_next >= loop_limit_ff);

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      walk_in        = walk_ff;
      rem_in         = rem_ff;
      cur_in         = cur_ff;
      pass_in        = pass_ff;
      stopped_in     = stopped_ff;
      loop_limit_in  = loop_limit_ff;
      frame_count_in = frame_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rd_en          = 1'b0;
      rd_frame       = walk_ff;

      // configuration writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOOP_LIMIT:  loop_limit_in  = csr_data;
            CSR_FRAME_COUNT: frame_count_in = csr_data[COUNT_W-1:0];
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               walk_in  = cur_ff;
               rem_in   = req_elapsed;
               state_in = ST_DONE;
               // start a walk unless there is nothing to do
               if ((req_tuser == CMD_ADVANCE) && !stopped_ff &&
                   (active_count >= COUNT_W'(2)) &&
                   (COUNT_W'(cur_ff) < active_count)) begin
                  rd_en    = 1'b1;
                  rd_frame = cur_ff;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!step.fits) begin
               state_in = ST_DONE;
            end else begin
               rem_in = step.remaining;
               if (next_frame >= active_count) begin
                  pass_in = pass_next;
                  if (limit_hit) begin
                     // park on the last frame
                     walk_in    = FRAME_W'(active_count - COUNT_W'(1));
                     stopped_in = 1'b1;
                     state_in   = ST_DONE;
                  end else begin
                     walk_in  = '0;
                     rd_en    = 1'b1;
                     rd_frame = '0;
                  end
               end else begin
                  walk_in  = next_frame[FRAME_W-1:0];
                  rd_en    = 1'b1;
                  rd_frame = next_frame[FRAME_W-1:0];
               end
            end
         end
         ST_DONE: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, stopped_ff, pass_ff, walk_ff, (walk_ff != cur_ff)};
               cur_in       = walk_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cur_ff         <= '0;
         pass_ff        <= '0;
         stopped_ff     <= 1'b0;
         loop_limit_ff  <= '0;
         frame_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_ff         <= cur_in;
         pass_ff        <= pass_in;
         stopped_ff     <= stopped_in;
         loop_limit_ff  <= loop_limit_in;
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      walk_ff     <= walk_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   // delay table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_mem[wr_addr] <= req_delay;
      end
      if (rd_en) begin
         rd_data_ff <= delay_mem[rd_addr];
      end
   end

endmodule

[hw/rtl/afs_step_unit.sv]
// Shared time step of the frame walk: scales one delay to milliseconds and
// checks and subtracts it from the remaining time. Depends on afs_pkg.
module afs_step_unit
   import afs_pkg::*;
(
   input  logic [TIME_W-1:0]  remaining,
   input  logic [DELAY_W-1:0] frame_delay,
   output step_result_type    result
);

   logic [DUR_W-1:0] duration;
   logic [DUR_W-1:0] remaining_ext;

   // ten ms per centisecond as shift and add
   assign duration      = (DUR_W'(frame_delay) << 3) + (DUR_W'(frame_delay) << 1);
   assign remaining_ext = DUR_W'(remaining);

   // compare and subtract
   assign result.fits      = (duration != '0) && (remaining_ext >= duration);
   assign result.remaining = remaining - duration[TIME_W-1:0];

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for animation_frame_scheduler_core: random and directed requests,
// each response checked against an in-bench model of the frame walk. Depends on afs_pkg.
module tb;
   import afs_pkg::*;

   localparam int FRAMES      = DEFAULT_MAX_FRAMES;
   localparam int STALL_LIMIT = 20000;   // longest walk steps over 6553 frames

   typedef struct packed {
      logic               changed;
      logic [FRAME_W-1:0] frame;
      logic [PASS_W-1:0]  loops;
      logic               done;
   } frame_status_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // frame_slot[7:0], frame_delay[23:8], elapsed_time[39:24]
   logic        req_tuser  = 1'b0; // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // changed[0], frame_index[8:1], loops_done[24:9],
                                   // done_res[25], zero[31:26]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_data   = '0;

   animation_frame_scheduler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model state of the scheduler
   bit [DELAY_W-1:0] delay_tbl [FRAMES];
   bit               tbl_written [FRAMES];
   int unsigned      cur_frame = 0;
   int unsigned      passes    = 0;
   bit               halted    = 1'b0;
   logic [15:0]      limit_cfg = '0;
   logic [8:0]       count_cfg = '0;

   frame_status_type expected_status [$];

   int unsigned      burst_left     = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      request_count  = 0;
   int unsigned      advance_count  = 0;
   int unsigned      moved_count    = 0;
   int unsigned      response_count = 0;
   int unsigned      setting_count  = 0;
   int unsigned      stalled_cycles = 0;

   function automatic int unsigned active_frames();
      return (count_cfg > FRAMES) ? FRAMES : count_cfg;
   endfunction

   // apply one request to the model, return the status it must produce
   function automatic frame_status_type schedule_step(input logic cmd, input logic [7:0] slot,
                                                      input logic [15:0] delay,
                                                      input logic [15:0] elapsed);
      frame_status_type s;
      int unsigned   span, f, left, dur;
      bit            walking;
      bit            moved;
      moved = 1'b0;
      if (cmd == CMD_WRITE_DELAY) begin
         delay_tbl[slot]   = delay;
         tbl_written[slot] = 1'b1;
      end else begin
         span = active_frames();
         if (!halted && span >= 2 && cur_frame < span) begin
            f       = cur_frame;
            left    = elapsed;
            walking = 1'b1;
            while (walking) begin
               dur = delay_tbl[f] * 10;
               if (dur == 0 || left < dur) begin
                  walking = 1'b0;
               end else begin
                  left -= dur;
                  f++;
                  // end of a pass: count it, then wrap or park
                  if (f >= span) begin
                     if (passes < PASS_MAX) passes++;
                     if (limit_cfg != 0 && passes >= limit_cfg) begin
                        f       = span - 1;
                        halted  = 1'b1;
                        walking = 1'b0;
                     end else begin
                        f = 0;
                     end
                  end
               end
            end
            if (f != cur_frame) begin
               cur_frame = f;
               moved     = 1'b1;
            end
         end
      end
      s.changed = moved;
      s.frame   = cur_frame[7:0];
      s.loops   = passes[15:0];
      s.done    = halted;
      return s;
   endfunction

   // milliseconds that exactly cover the next k frames from the current one
   function automatic logic [15:0] ms_to_cover(input int unsigned k);
      int unsigned f, sum, span;
      span = active_frames();
      f    = cur_frame;
      sum  = 0;
      if (cur_frame >= span) return 16'd0;
      repeat (k) begin
         if (delay_tbl[f] == 0) break;
         sum += delay_tbl[f] * 10;
         f = (f + 1) % span;
      end
      return (sum > 65535) ? 16'hFFFF : sum[15:0];
   endfunction

   function automatic logic [15:0] pick_delay();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'd0;
      if (r < 16) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(1, 40));
   endfunction

   function automatic logic [15:0] pick_elapsed();
      int unsigned r;
      logic [15:0] span_ms;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'($urandom_range(0, 20));
      if (r < 35) begin
         // land exactly on a frame boundary, or one short of it
         span_ms = ms_to_cover($urandom_range(1, 8));
         if (r[0] && span_ms != 0) span_ms--;
         return span_ms;
      end
      if (r < 75) return 16'($urandom_range(0, 1500));
      if (r < 93) return 16'($urandom_range(0, 8000));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] far_limit();
      int unsigned v;
      v = passes + 20000 + $urandom_range(0, 20000);
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("[%0t] response %0d: %s expected %0h got %0h",
                  $realtime, response_count, what, want, got);
   endtask

   // one request, with bursts and random gaps in front of it
   task automatic send_request(input logic cmd, input logic [7:0] slot,
                               input logic [15:0] delay, input logic [15:0] elapsed);
      int unsigned gap;
      frame_status_type s;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {elapsed, delay, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      s = schedule_step(cmd, slot, delay, elapsed);
      expected_status.push_back(s);
      request_count++;
      if (cmd == CMD_ADVANCE) advance_count++;
      if (s.changed) moved_count++;
   endtask

   task automatic write_delay(input logic [7:0] slot, input logic [15:0] delay);
      send_request(CMD_WRITE_DELAY, slot, delay, 16'($urandom_range(0, 65535)));
   endtask

   task automatic advance_by(input logic [15:0] ms);
      send_request(CMD_ADVANCE, 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), ms);
   endtask

   // hold requests until every response is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers, back to back on the write channel
   task automatic configure(input logic [15:0] limit, input logic [15:0] count);
      csr_valid <= 1'b1;
      csr_index <= CSR_LOOP_LIMIT;
      csr_data  <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_cfg = limit;
      csr_index <= CSR_FRAME_COUNT;
      csr_data  <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      count_cfg = count[8:0];
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // every frame an advance can reach must hold a written delay
   task automatic load_missing_delays();
      int f;
      for (f = 0; f < active_frames(); f++)
         if (!tbl_written[f]) write_delay(f[7:0], pick_delay());
   endtask

   task automatic test_basic_walk();
      configure(16'd0, 16'd4);
      write_delay(8'd0, 16'd5);
      write_delay(8'd1, 16'd1);
      write_delay(8'd2, 16'd3);
      write_delay(8'd3, 16'd2);
      advance_by(16'd0);
      advance_by(16'd49);
      advance_by(16'd50);
      advance_by(16'hFFFF);
      write_delay(8'd255, 16'hFFFF);
   endtask

   task automatic test_zero_and_huge_delay();
      // zero delay halts the walk, a delay beyond any elapsed time never fits
      write_delay(8'd2, 16'd0);
      advance_by(16'hFFFF);
      advance_by(16'd100);
      write_delay(8'd2, 16'hFFFF);
      advance_by(16'hFFFF);
      write_delay(8'd2, 16'd3);
      advance_by(16'd30);
   endtask

   task automatic test_inactive_advance();
      // fewer than two frames, then a current frame beyond the count
      wait_idle();
      configure(16'd0, 16'd0);
      advance_by(16'd1000);
      write_delay(8'd1, 16'd1);
      wait_idle();
      configure(16'd0, 16'd1);
      advance_by(16'd1000);
      wait_idle();
      configure(16'd0, 16'd2);
      advance_by(16'd1000);
      wait_idle();
      configure(16'd0, 16'd4);
      advance_by(16'd10);
   endtask

   task automatic run_random_phase(input logic [15:0] limit, input int unsigned count_lo,
                                   input int unsigned count_hi, input int unsigned n);
      int unsigned lo, count, span;
      logic [7:0]  slot;
      wait_idle();
      lo    = (cur_frame + 1 > count_lo) ? cur_frame + 1 : count_lo;
      count = (lo >= count_hi) ? lo : $urandom_range(lo, count_hi);
      configure(limit, count[15:0]);
      load_missing_delays();
      span = active_frames();
      repeat (n) begin
         if ($urandom_range(0, 59) == 0) wait_idle();
         if ($urandom_range(0, 9) < 3) begin
            slot = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, span - 1));
            write_delay(slot, pick_delay());
         end else begin
            advance_by(pick_elapsed());
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(16'd0, 2, 2, 100);
      run_random_phase(16'hFFFF, 5, 12, 170);
      run_random_phase(far_limit(), 2, 40, 170);
      run_random_phase(16'd0, 511, 511, 150);   // count beyond the table
      run_random_phase(far_limit(), 256, 256, 130);
      run_random_phase(16'd0, 3, 24, 230);
      run_random_phase(16'hFFFF, 2, 6, 170);
   endtask

   task automatic test_pass_saturation();
      int unsigned guard;
      wait_idle();
      // bring the current frame back to 0 through an end of pass
      if (cur_frame >= 2) begin
         configure(16'd0, 16'(cur_frame + 1));
         write_delay(cur_frame[7:0], 16'd1);
         advance_by(16'd10);
         wait_idle();
      end
      configure(16'd0, 16'd2);
      write_delay(8'd0, 16'd1);
      write_delay(8'd1, 16'd1);
      guard = 0;
      while (passes < PASS_MAX && !halted && guard < 40) begin
         advance_by(16'hFFFF);
         guard++;
      end
      advance_by(16'hFFFF);
      // saturated count meets the largest limit: park on the last frame
      wait_idle();
      configure(16'hFFFF, 16'd2);
      advance_by(16'hFFFF);
      advance_by(16'd500);
      write_delay(8'd1, 16'd7);
   endtask

   // response checker
   always @(posedge clock) begin : check_status
      frame_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         response_count++;
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected response", 32'd0, rsp_tdata);
         end else begin
            want = expected_status.pop_front();
            if (rsp_tdata[0] !== want.changed)
               report_mismatch("changed", 32'(want.changed), 32'(rsp_tdata[0]));
            if (rsp_tdata[8:1] !== want.frame)
               report_mismatch("frame_index", 32'(want.frame), 32'(rsp_tdata[8:1]));
            if (rsp_tdata[24:9] !== want.loops)
               report_mismatch("loops_done", 32'(want.loops), 32'(rsp_tdata[24:9]));
            if (rsp_tdata[25] !== want.done)
               report_mismatch("done_res", 32'(want.done), 32'(rsp_tdata[25]));
            if (rsp_tdata[31:26] !== 6'd0)
               report_mismatch("padding", 32'd0, 32'(rsp_tdata[31:26]));
         end
      end
   end

   // response back-pressure: always ready, random, or a periodic stall
   int unsigned ready_mode = 0, mode_left = 0, ready_tick = 0;
   int unsigned ready_period = 4, stall_len = 1;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode   = $urandom_range(0, 2);
         mode_left    = $urandom_range(50, 300);
         ready_period = $urandom_range(4, 20);
         stall_len    = $urandom_range(1, ready_period - 1);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= ((ready_tick % ready_period) >= stall_len);
         end
      endcase
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     stalled_cycles, expected_status.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_basic_walk();
      test_zero_and_huge_delay();
      test_inactive_advance();
      test_random_traffic();
      test_pass_saturation();
      wait_idle();
      repeat (16) @(posedge clock);
      $display("covered %0d requests (%0d advances, %0d frame moves), %0d register settings",
               request_count, advance_count, moved_count, setting_count);
      $display("pass count reached %0d, finished flag %0d, %0d responses checked",
               passes, halted, response_count);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
